// ----- sv/acb_pkg.sv -----
// Package for the trie builder: request and status codes and letter folding.
// No dependencies.
package acb_pkg;
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOTLET  = 2'd2;

    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Offset of the byte from 'a' after case folding.
    function automatic logic [7:0] fold_off(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            c = b + 8'h20;
        end
        return c - CH_LOW_A;
    endfunction

    function automatic logic below_a(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            c = b + 8'h20;
        end
        return c < CH_LOW_A;
    endfunction
endpackage

// ----- sv/aho_corasick_trie_builder.sv -----
// Trie builder with breadth-first failure-link construction.
// Depends on acb_pkg.
//
// channel  direction  signals
// in       input      i_valid/o_ready, i_req_type, i_letter_byte, i_node_select
// out      output     o_valid/i_ready, o_status .. o_node_count
//
// Inserts of a letter and reads go through a read state, a data state and S_OUT before
// o_valid, set by the registered reads of the node memories; word ends, carriage returns,
// rejected bytes and unknown requests go straight to S_OUT.
// A build walks every child slot of every queued node and follows each failure chain
// step by step, one memory read at a time.
// After reset a clearing pass writes zero to each child entry, one per cycle,
// with o_ready low.
// A result waits in the output register; the next request is taken only after it leaves.
module aho_corasick_trie_builder
    import acb_pkg::*;
#(
    parameter int NODE_COUNT    = 256,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_letter_byte,
    input  logic [7:0] i_node_select,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_node_id,
    output logic [7:0] o_failure_link,
    output logic       o_is_terminal,
    output logic [7:0] o_node_depth,
    output logic [7:0] o_child_node,
    output logic [8:0] o_node_count
);
    localparam int NW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int AW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CD   = NODE_COUNT * ALPHABET_SIZE;
    localparam int CW   = $clog2(CD);
    localparam int UW   = NW + 1;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_INS_R = 5'd2;
    localparam logic [4:0] S_INS_D = 5'd3;
    localparam logic [4:0] S_RD_R  = 5'd4;
    localparam logic [4:0] S_RD_D  = 5'd5;
    localparam logic [4:0] S_OUT   = 5'd6;
    localparam logic [4:0] S_B0_R  = 5'd7;
    localparam logic [4:0] S_B0_D  = 5'd8;
    localparam logic [4:0] S_BQ    = 5'd9;
    localparam logic [4:0] S_BQ_D  = 5'd10;
    localparam logic [4:0] S_BC_R  = 5'd11;
    localparam logic [4:0] S_BC_D  = 5'd12;
    localparam logic [4:0] S_BF_R  = 5'd13;
    localparam logic [4:0] S_BF_D  = 5'd14;
    localparam logic [4:0] S_BP_R  = 5'd15;
    localparam logic [4:0] S_BP_D  = 5'd16;
    localparam logic [4:0] S_BNEXT = 5'd17;
    localparam logic [4:0] S_BFF_D = 5'd18;

    logic [NW-1:0] m_child [CD];
    logic [NW-1:0] m_fail  [NODE_COUNT];
    logic [7:0]    m_depth [NODE_COUNT];
    logic [NW-1:0] m_queue [NODE_COUNT];
    logic          m_term  [NODE_COUNT];

    logic [4:0]    r_state;
    logic [CW-1:0] r_caddr;
    logic [NW-1:0] r_cdata;
    logic [NW-1:0] r_fdata;
    logic [7:0]    r_ddata;
    logic [NW-1:0] r_qdata;
    logic          r_tdata;
    logic [UW-1:0] r_used;
    logic [NW-1:0] r_cursor;
    logic          r_drop;
    logic [UW-1:0] r_head, r_tail;
    logic [NW-1:0] r_u, r_v, r_p;
    logic [AW-1:0] r_c;
    logic [7:0]    r_sel;
    logic          r_notlet;
    logic          r_selok;
    logic          r_ovalid;
    logic [1:0]    r_status;
    logic [7:0]    r_id, r_fl, r_dep, r_ch;
    logic          r_tm;

    // Memory control from the sequencer.
    logic          c_we;
    logic [CW-1:0] c_wa;
    logic [NW-1:0] c_wd;
    logic          f_we;
    logic [NW-1:0] f_wa, f_wd, f_ra;
    logic          d_we;
    logic [NW-1:0] d_wa;
    logic [7:0]    d_wd;
    logic          q_we;
    logic [NW-1:0] q_wa, q_ra;
    logic [CW-1:0] c_ra;
    logic          t_we;
    logic [NW-1:0] t_wa, t_ra;
    logic          t_wd;

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            m_child[c_wa] <= c_wd;
        end
        r_cdata <= m_child[c_ra];
        if (f_we) begin
            m_fail[f_wa] <= f_wd;
        end
        r_fdata <= m_fail[f_ra];
        if (d_we) begin
            m_depth[d_wa] <= d_wd;
        end
        r_ddata <= m_depth[f_ra];
        if (q_we) begin
            m_queue[q_wa] <= r_cdata;
        end
        r_qdata <= m_queue[q_ra];
        if (t_we) begin
            m_term[t_wa] <= t_wd;
        end
        r_tdata <= m_term[t_ra];
    end

    function automatic logic [CW-1:0] caddr(input logic [NW-1:0] n, input logic [AW-1:0] c);
        return CW'(n * ALPHABET_SIZE) + CW'(c);
    endfunction

    logic          ib_let, ib_end;
    logic [7:0]    ib_off;
    assign ib_off = fold_off(i_letter_byte);
    assign ib_let = !below_a(i_letter_byte) && (32'(ib_off) < ALPHABET_SIZE);
    assign ib_end = (i_letter_byte == CH_NL) || (i_letter_byte == CH_NUL);

    logic acc_in;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign acc_in  = i_valid && o_ready;
    logic [7:0] nd;
    assign nd = (r_ddata == 8'hFF) ? 8'hFF : r_ddata + 8'd1;

    always_comb begin
        c_we = 1'b0; c_wa = r_caddr; c_wd = '0;
        f_we = 1'b0; f_wa = r_v; f_wd = '0;
        d_we = 1'b0; d_wa = r_used[NW-1:0]; d_wd = nd;
        q_we = 1'b0; q_wa = r_tail[NW-1:0]; q_ra = r_head[NW-1:0];
        t_we = 1'b0; t_wa = r_used[NW-1:0]; t_wd = 1'b0; t_ra = r_v;
        c_ra = r_caddr;
        f_ra = r_p;
        case (r_state)
            S_CLR: begin
                c_we = 1'b1;
                f_we = 1'b1; f_wa = r_caddr[NW-1:0];
                d_we = 1'b1; d_wa = r_caddr[NW-1:0]; d_wd = '0;
                t_we = 1'b1; t_wa = r_caddr[NW-1:0];
            end
            S_INS_R: f_ra = r_cursor;
            S_RD_R: begin
                f_ra = r_sel[NW-1:0];
                t_ra = r_sel[NW-1:0];
            end
            default: ;
        endcase
        if (r_state == S_IDLE && acc_in && i_req_type == REQ_INSERT && ib_end && !r_drop) begin
            t_we = 1'b1; t_wa = r_cursor; t_wd = 1'b1;
        end
        if (r_state == S_INS_D && r_cdata == '0 && r_used < UW'(NODE_COUNT)) begin
            c_we = 1'b1; c_wd = r_used[NW-1:0];
            f_we = 1'b1; f_wa = r_used[NW-1:0];
            d_we = 1'b1;
            t_we = 1'b1;
        end
        if (r_state == S_B0_D && r_cdata != '0) begin
            f_we = 1'b1; f_wa = r_cdata; q_we = 1'b1;
        end
        if (r_state == S_BFF_D) begin
            f_we = 1'b1; f_wd = (r_tdata) ? '0 : r_cdata;
        end
        if (r_state == S_BC_D && r_cdata != '0 && r_tail < UW'(NODE_COUNT)) begin
            q_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_caddr  <= '0;
            r_used   <= UW'(1);
            r_cursor <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + CW'(1);
                    if (32'(r_caddr) == CD - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc_in) begin
                        r_sel    <= i_node_select;
                        r_notlet <= !ib_let;
                        r_selok  <= 32'(i_node_select) < NODE_COUNT;
                        r_status <= ST_OK;
                        r_id <= '0; r_fl <= '0; r_dep <= '0; r_ch <= '0; r_tm <= 1'b0;
                        case (i_req_type)
                            REQ_INSERT: begin
                                if (ib_end) begin
                                    r_cursor <= '0;
                                    r_drop   <= 1'b0;
                                    r_state  <= S_OUT;
                                end else if (i_letter_byte == CH_CR) begin
                                    r_id <= 8'(r_cursor); r_state <= S_OUT;
                                end else if (r_drop) begin
                                    r_status <= ST_FULL; r_id <= 8'(r_cursor);
                                    r_state <= S_OUT;
                                end else if (!ib_let) begin
                                    r_status <= ST_NOTLET; r_id <= 8'(r_cursor);
                                    r_state <= S_OUT;
                                end else begin
                                    r_caddr <= caddr(r_cursor, ib_off[AW-1:0]);
                                    r_state <= S_INS_R;
                                end
                            end
                            REQ_BUILD: begin
                                r_head <= '0; r_tail <= '0; r_c <= '0;
                                r_caddr <= caddr('0, '0);
                                r_state <= S_B0_R;
                            end
                            REQ_READ: begin
                                r_id <= i_node_select;
                                r_caddr <= caddr(i_node_select[NW-1:0], ib_off[AW-1:0]);
                                r_state <= S_RD_R;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_INS_R: r_state <= S_INS_D;
                S_INS_D: begin
                    if (r_cdata != '0) begin
                        r_cursor <= r_cdata; r_id <= 8'(r_cdata);
                    end else if (r_used < UW'(NODE_COUNT)) begin
                        r_cursor <= r_used[NW-1:0];
                        r_id <= 8'(r_used);
                        r_used <= r_used + UW'(1);
                    end else begin
                        r_status <= ST_FULL; r_drop <= 1'b1; r_id <= 8'(r_cursor);
                    end
                    r_state <= S_OUT;
                end
                S_RD_R: r_state <= S_RD_D;
                S_RD_D: begin
                    if (r_selok) begin
                        r_fl  <= 8'(r_fdata);
                        r_dep <= r_ddata;
                        r_tm  <= r_tdata;
                    end
                    if (r_notlet) begin
                        r_status <= ST_NOTLET;
                    end else if (r_selok) begin
                        r_ch <= 8'(r_cdata);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_B0_R: begin
                    r_state <= S_B0_D;
                end
                S_B0_D: begin
                    if (r_cdata != '0) begin
                        r_tail <= r_tail + UW'(1);
                    end
                    if (32'(r_c) == ALPHABET_SIZE - 1) begin
                        r_state <= S_BQ;
                    end else begin
                        r_c <= r_c + AW'(1);
                        r_caddr <= caddr('0, r_c + AW'(1));
                        r_state <= S_B0_R;
                    end
                end
                S_BQ: begin
                    if (r_head < r_tail) begin
                        r_state <= S_BQ_D;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_BQ_D: begin
                    r_u <= r_qdata;
                    r_head <= r_head + UW'(1);
                    r_c <= '0;
                    r_caddr <= caddr(r_qdata, '0);
                    r_state <= S_BC_R;
                end
                S_BC_R: r_state <= S_BC_D;
                S_BC_D: begin
                    r_v <= r_cdata;
                    if (r_cdata == '0) begin
                        r_state <= S_BNEXT;
                    end else begin
                        if (r_tail < UW'(NODE_COUNT)) begin
                            r_tail <= r_tail + UW'(1);
                        end
                        r_p <= r_u;
                        r_state <= S_BF_R;
                    end
                end
                S_BF_R: r_state <= S_BF_D; // fail[p] read
                S_BF_D: begin
                    r_caddr <= caddr(r_fdata, r_c);
                    r_state <= S_BP_R;
                end
                S_BP_R: r_state <= S_BP_D;
                S_BP_D: begin
                    if (r_cdata == '0 && r_p != '0 && !r_tdata) begin
                        r_p <= r_fdata;
                        r_state <= S_BF_R;
                    end else begin
                        r_state <= S_BFF_D;
                    end
                end
                S_BFF_D: r_state <= S_BNEXT;
                S_BNEXT: begin
                    if (32'(r_c) == ALPHABET_SIZE - 1) begin
                        r_state <= S_BQ;
                    end else begin
                        r_c <= r_c + AW'(1);
                        r_caddr <= caddr(r_u, r_c + AW'(1));
                        r_state <= S_BC_R;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_node_id      = r_id;
    assign o_failure_link = r_fl;
    assign o_is_terminal  = r_tm;
    assign o_node_depth   = r_dep;
    assign o_child_node   = r_ch;
    assign o_node_count   = 9'(r_used);
endmodule

// ----- sv/acb_checker.sv -----
// Port checker for the trie builder, bound to the top level.
// Depends on acb_pkg.
module acb_checker
    import acb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic [8:0] o_node_count
);
    // No new request is taken while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped");
    // The node count never shrinks outside reset.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_node_count >= $past(o_node_count))
        else $error("node count decreased");
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_FULL || o_status == ST_NOTLET)
        else $error("bad status");
endmodule

bind aho_corasick_trie_builder acb_checker u_acb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_node_count(o_node_count)
);
